>>> sv/llp_pkg.sv
// Shared types and codes for the linked-list pool with free list.
// Used by llp_ctrl, llp_dpath and linked_list_pool_with_free_list.
// No dependencies.
package llp_pkg;

	// Operation codes carried in the op field
	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_COUNT  = 2'd3
	} op_t;

	// Status codes returned in the status field
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	// Kind of result the datapath builds into the output word
	typedef enum logic [2:0] {
		RES_COUNT = 3'd0,
		RES_FULL  = 3'd1,
		RES_MISS  = 3'd2,
		RES_INS   = 3'd3,
		RES_HIT   = 3'd4
	} res_t;

	// Stream word widths
	localparam int IN_DATA_W  = 104;
	localparam int OUT_DATA_W = 80;
	localparam int KEY_W      = 32;

	// Commands from controller to datapath
	typedef struct packed {
		logic load_in;    // capture the input word
		logic walk_start; // read the head slot, start the list walk
		logic walk_step;  // follow the link of the current slot
		logic ins_pop_rd; // read the link of the free-list head
		logic ins_pop;    // pop the free-list head
		logic ins_hw;     // take the next never-used slot
		logic ins_write;  // write the new record and link it at the head
		logic rm_unlink;  // bypass the matched slot in the list
		logic rm_free;    // push the matched slot onto the free list
		logic out_load;   // load the output register
		res_t res;        // what goes into the output register
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		op_t  op;
		logic free_valid; // free list not empty
		logic hw_avail;   // never-used slots remain
		logic head_valid; // list not empty
		logic key_match;  // slot under the walk holds the key
		logic link_null;  // slot under the walk ends the list
		logic walk_last;  // walk has visited the whole pool
	} sts_t;

endpackage

>>> sv/llp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds the pool's links, keys and payloads. No dependencies.
module llp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> sv/llp_dpath.sv
// Datapath of the linked-list pool: pointer registers, walk registers,
// link and key/payload memories, output register. Uses llp_pkg, llp_ram.
module llp_dpath #(
	parameter int POOL_DEPTH   = 64,
	parameter int RECORD_WIDTH = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [llp_pkg::IN_DATA_W-1:0]    s_tdata,
	input  llp_pkg::cmd_t                    cmd,
	output llp_pkg::sts_t                    sts,
	output logic [llp_pkg::OUT_DATA_W-1:0]   m_tdata
);

	localparam int SLOT_W = $clog2(POOL_DEPTH);
	localparam int LINK_W = $clog2(POOL_DEPTH + 1);
	localparam int KV_W   = llp_pkg::KEY_W + RECORD_WIDTH;
	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_DEPTH);

	// Captured input word
	llp_pkg::op_t              op_q;
	logic [llp_pkg::KEY_W-1:0] key_q;
	logic [RECORD_WIDTH-1:0]   rec_q;

	// List state
	logic [LINK_W-1:0] head_q, free_q, hw_q, cnt_q, cnt_d;

	// Walk and allocation registers
	logic [SLOT_W-1:0] cur_q, slot_q;
	logic [LINK_W-1:0] prev_q, steps_q;

	logic [llp_pkg::OUT_DATA_W-1:0] m_tdata_q;

	// Memory ports
	logic [SLOT_W-1:0] rd_addr, link_waddr;
	logic [LINK_W-1:0] link_rd, link_wdata;
	logic              link_we, link_re, prev_valid;
	logic [KV_W-1:0]   kv_rd;

	assign prev_valid = (prev_q < NULL_LINK);

	// Read address: head on walk start, followed link on a step, free head on pop
	always_comb begin
		rd_addr = head_q[SLOT_W-1:0];
		if (cmd.walk_step) begin
			rd_addr = link_rd[SLOT_W-1:0];
		end else if (cmd.ins_pop_rd) begin
			rd_addr = free_q[SLOT_W-1:0];
		end
	end
	assign link_re = cmd.walk_start | cmd.walk_step | cmd.ins_pop_rd;

	// Link write: new head link, bypass on remove, or free-list push
	always_comb begin
		link_we    = 1'b0;
		link_waddr = slot_q;
		link_wdata = head_q;
		if (cmd.ins_write) begin
			link_we = 1'b1;
		end else if (cmd.rm_unlink && prev_valid) begin
			link_we    = 1'b1;
			link_waddr = prev_q[SLOT_W-1:0];
			link_wdata = link_rd;
		end else if (cmd.rm_free) begin
			link_we    = 1'b1;
			link_waddr = cur_q;
			link_wdata = free_q;
		end
	end

	llp_ram #(
		.WIDTH(LINK_W),
		.DEPTH(POOL_DEPTH)
	) u_link_ram (
		.clk  (clk),
		.we   (link_we),
		.waddr(link_waddr),
		.wdata(link_wdata),
		.re   (link_re),
		.raddr(rd_addr),
		.rdata(link_rd)
	);

	llp_ram #(
		.WIDTH(KV_W),
		.DEPTH(POOL_DEPTH)
	) u_kv_ram (
		.clk  (clk),
		.we   (cmd.ins_write),
		.waddr(slot_q),
		.wdata({rec_q, key_q}),
		.re   (cmd.walk_start | cmd.walk_step),
		.raddr(rd_addr),
		.rdata(kv_rd)
	);

	// Record count after this cycle's update
	always_comb begin
		cnt_d = cnt_q;
		if (cmd.ins_write) begin
			cnt_d = cnt_q + LINK_W'(1);
		end else if (cmd.rm_free && (cnt_q != '0)) begin
			cnt_d = cnt_q - LINK_W'(1);
		end
	end

	// List state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= NULL_LINK;
			free_q <= NULL_LINK;
			hw_q   <= '0;
			cnt_q  <= '0;
		end else begin
			cnt_q <= cnt_d;
			if (cmd.ins_write) begin
				head_q <= LINK_W'(slot_q);
			end else if (cmd.rm_unlink && !prev_valid) begin
				head_q <= link_rd;
			end
			if (cmd.ins_pop) begin
				free_q <= link_rd;
			end else if (cmd.rm_free) begin
				free_q <= LINK_W'(cur_q);
			end
			if (cmd.ins_hw) begin
				hw_q <= hw_q + LINK_W'(1);
			end
		end
	end

	// Output fields, zero-extended or cut to their port widths
	logic [SLOT_W+5:0]       slot_wide;
	logic [LINK_W+6:0]       cnt_wide;
	logic [63+RECORD_WIDTH:0] rec_wide;
	logic [SLOT_W-1:0]       res_slot;
	logic [63:0]             res_rec;
	llp_pkg::status_t        res_status;

	always_comb begin
		res_status = llp_pkg::ST_OK;
		res_slot   = '0;
		res_rec    = '0;
		rec_wide   = {64'd0, kv_rd[KV_W-1:llp_pkg::KEY_W]};
		case (cmd.res)
			llp_pkg::RES_FULL: res_status = llp_pkg::ST_FULL;
			llp_pkg::RES_MISS: res_status = llp_pkg::ST_MISS;
			llp_pkg::RES_INS:  res_slot   = slot_q;
			llp_pkg::RES_HIT: begin
				res_slot = cur_q;
				res_rec  = rec_wide[63:0];
			end
			default: res_status = llp_pkg::ST_OK;
		endcase
		slot_wide = {6'd0, res_slot};
		cnt_wide  = {7'd0, cnt_d};
	end

	// Input capture, walk registers and output register
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q  <= llp_pkg::op_t'(s_tdata[1:0]);
			key_q <= s_tdata[33:2];
			rec_q <= s_tdata[34 +: RECORD_WIDTH];
		end
		if (cmd.walk_start) begin
			cur_q   <= head_q[SLOT_W-1:0];
			prev_q  <= NULL_LINK;
			steps_q <= LINK_W'(1);
		end else if (cmd.walk_step) begin
			cur_q   <= link_rd[SLOT_W-1:0];
			prev_q  <= LINK_W'(cur_q);
			steps_q <= steps_q + LINK_W'(1);
		end
		if (cmd.ins_pop_rd) begin
			slot_q <= free_q[SLOT_W-1:0];
		end else if (cmd.ins_hw) begin
			slot_q <= hw_q[SLOT_W-1:0];
		end
		if (cmd.out_load) begin
			m_tdata_q <= {1'b0, cnt_wide[6:0], res_rec, slot_wide[5:0], res_status};
		end
	end

	assign m_tdata = m_tdata_q;

	// Status toward the controller
	always_comb begin
		sts.op         = op_q;
		sts.free_valid = (free_q < NULL_LINK);
		sts.hw_avail   = (hw_q < NULL_LINK);
		sts.head_valid = (head_q < NULL_LINK);
		sts.key_match  = (kv_rd[llp_pkg::KEY_W-1:0] == key_q);
		sts.link_null  = !(link_rd < NULL_LINK);
		sts.walk_last  = (steps_q == NULL_LINK);
	end

endmodule

>>> sv/llp_ctrl.sv
// Controller of the linked-list pool: sequences insert, walk, remove and
// count, and owns the stream handshakes. Uses llp_pkg.
module llp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          in_ready,
	input  logic          m_tready,
	output logic          out_valid,
	input  llp_pkg::sts_t sts,
	output llp_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		IDLE,
		DECODE,
		INS_POP,
		INS_WRITE,
		WALK,
		RM_UNLINK,
		RM_FREE
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	// Output register can take a word this cycle
	assign out_free = !out_valid_q || m_tready;
	assign in_ready = (state_q == IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.res = llp_pkg::RES_COUNT;
		case (state_q)
			IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = DECODE;
				end
			end
			DECODE: begin
				case (sts.op)
					llp_pkg::OP_INSERT: begin
						if (sts.free_valid) begin
							cmd.ins_pop_rd = 1'b1;
							state_d        = INS_POP;
						end else if (sts.hw_avail) begin
							cmd.ins_hw = 1'b1;
							state_d    = INS_WRITE;
						end else if (out_free) begin
							cmd.out_load = 1'b1;
							cmd.res      = llp_pkg::RES_FULL;
							state_d      = IDLE;
						end
					end
					llp_pkg::OP_REMOVE, llp_pkg::OP_LOOKUP: begin
						if (sts.head_valid) begin
							cmd.walk_start = 1'b1;
							state_d        = WALK;
						end else if (out_free) begin
							cmd.out_load = 1'b1;
							cmd.res      = llp_pkg::RES_MISS;
							state_d      = IDLE;
						end
					end
					llp_pkg::OP_COUNT: begin
						if (out_free) begin
							cmd.out_load = 1'b1;
							cmd.res      = llp_pkg::RES_COUNT;
							state_d      = IDLE;
						end
					end
					default: state_d = IDLE;
				endcase
			end
			INS_POP: begin
				cmd.ins_pop = 1'b1;
				state_d     = INS_WRITE;
			end
			INS_WRITE: begin
				if (out_free) begin
					cmd.ins_write = 1'b1;
					cmd.out_load  = 1'b1;
					cmd.res       = llp_pkg::RES_INS;
					state_d       = IDLE;
				end
			end
			WALK: begin
				if (sts.key_match) begin
					if (sts.op == llp_pkg::OP_REMOVE) begin
						state_d = RM_UNLINK;
					end else if (out_free) begin
						cmd.out_load = 1'b1;
						cmd.res      = llp_pkg::RES_HIT;
						state_d      = IDLE;
					end
				end else if (sts.link_null || sts.walk_last) begin
					if (out_free) begin
						cmd.out_load = 1'b1;
						cmd.res      = llp_pkg::RES_MISS;
						state_d      = IDLE;
					end
				end else begin
					cmd.walk_step = 1'b1;
				end
			end
			RM_UNLINK: begin
				cmd.rm_unlink = 1'b1;
				state_d       = RM_FREE;
			end
			RM_FREE: begin
				if (out_free) begin
					cmd.rm_free  = 1'b1;
					cmd.out_load = 1'b1;
					cmd.res      = llp_pkg::RES_HIT;
					state_d      = IDLE;
				end
			end
			default: state_d = IDLE;
		endcase
	end

	// State and output-valid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> sv/linked_list_pool_with_free_list.sv
// Keyed linked list in a pool of POOL_DEPTH slots, with a free list of
// released slots and a high-water mark for slots never used. One word is in
// work at a time; a new word is taken while the previous answer still waits
// on the output side. The list walk visits one slot per cycle, bounded by
// the registered read of the link memory, whose output addresses the next
// read. Insert on a full pool answers "pool full"; a key not in the list
// answers "not found".
// Depends on llp_pkg, llp_ctrl, llp_dpath, llp_ram.
module linked_list_pool_with_free_list #(
	parameter int POOL_DEPTH   = 64,
	parameter int RECORD_WIDTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// op[1:0], key[33:2], record[97:34], zero pad[103:98]
	input  logic [llp_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// status[1:0], slot[7:2], found_record[71:8], entries[78:72], zero pad[79]
	output logic [llp_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

	llp_pkg::cmd_t cmd;
	llp_pkg::sts_t sts;

	llp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.m_tready (m_axis_tready),
		.out_valid(m_axis_tvalid),
		.sts      (sts),
		.cmd      (cmd)
	);

	llp_dpath #(
		.POOL_DEPTH  (POOL_DEPTH),
		.RECORD_WIDTH(RECORD_WIDTH)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.s_tdata(s_axis_tdata),
		.cmd    (cmd),
		.sts    (sts),
		.m_tdata(m_axis_tdata)
	);

`ifndef SYNTHESIS
	// An answer is never loaded over one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(m_axis_tvalid && !m_axis_tready))
		else $error("output word overwritten");

	// Only one word in work: no acceptance right after one
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("second word accepted while busy");

	// A loaded answer is offered on the next cycle
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> m_axis_tvalid)
		else $error("loaded answer not offered");

	// List edits never coincide with a walk step
	a_no_edit_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_step |-> !(cmd.ins_write || cmd.rm_unlink || cmd.rm_free))
		else $error("list edited during walk");
`endif

endmodule

>>> sim/tb_linked_list_pool_with_free_list.sv
// Self-checking testbench for linked_list_pool_with_free_list: directed and
// random insert, remove, lookup and count words checked against a behavioral pool.
// Depends on llp_pkg and the RTL under sv/.
module tb_linked_list_pool_with_free_list;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int POOL_DEPTH   = 64;
	localparam int RECORD_WIDTH = 64;
	localparam int NULL_SLOT    = POOL_DEPTH;
	localparam logic [63:0] REC_MASK = {64{1'b1}} >> (64 - RECORD_WIDTH);
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = POOL_DEPTH + 16;
	localparam int RANDOM_WORDS = 250;

	// Expected answer word
	typedef struct packed {
		llp_pkg::status_t status;
		logic [5:0]       slot;
		logic [63:0]      found;
		logic [6:0]       entries;
	} pool_answer_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	// op[1:0], key[33:2], record[97:34], zero pad[103:98]
	logic [llp_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	// status[1:0], slot[7:2], found_record[71:8], entries[78:72], zero pad[79]
	logic [llp_pkg::OUT_DATA_W-1:0] m_axis_tdata;

	// Behavioral copy of the pool
	int          head_ptr;
	int          free_ptr;
	int          hwm;
	int          live;
	int          link_of [POOL_DEPTH];
	logic [31:0] key_of  [POOL_DEPTH];
	logic [63:0] rec_of  [POOL_DEPTH];

	pool_answer_t answers_due[$];
	int           errors = 0;
	int           idle_cycles = 0;
	bit           steady = 1'b0;

	linked_list_pool_with_free_list #(
		.POOL_DEPTH  (POOL_DEPTH),
		.RECORD_WIDTH(RECORD_WIDTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always #5 clk = ~clk;

	function automatic void pool_clear();
		head_ptr = NULL_SLOT;
		free_ptr = NULL_SLOT;
		hwm = 0;
		live = 0;
	endfunction

	// First slot from the head holding key; walk ends at a null link or after
	// visiting the whole pool
	function automatic bit find_slot(input logic [31:0] key, output int pos,
			output int prev);
		int cur;
		int back;
		cur = head_ptr;
		back = NULL_SLOT;
		pos = 0;
		prev = NULL_SLOT;
		for (int n = 0; n < POOL_DEPTH; n++) begin
			if (cur >= POOL_DEPTH)
				return 1'b0;
			if (key_of[cur] == key) begin
				pos = cur;
				prev = back;
				return 1'b1;
			end
			back = cur;
			cur = link_of[cur];
		end
		return 1'b0;
	endfunction

	// Apply one word to the pool copy and build its answer
	function automatic void pool_step(input llp_pkg::op_t op, input logic [31:0] key,
			input logic [63:0] rec, output pool_answer_t ans);
		int s;
		int pos;
		int prev;
		ans.status = llp_pkg::ST_OK;
		ans.slot = '0;
		ans.found = '0;
		case (op)
			llp_pkg::OP_INSERT: begin
				s = -1;
				if (free_ptr < POOL_DEPTH) begin
					s = free_ptr;
					free_ptr = link_of[s];
				end else if (hwm < POOL_DEPTH) begin
					s = hwm;
					hwm++;
				end
				if (s < 0) begin
					ans.status = llp_pkg::ST_FULL;
				end else begin
					key_of[s] = key;
					rec_of[s] = rec & REC_MASK;
					link_of[s] = head_ptr;
					head_ptr = s;
					live++;
					ans.slot = s[5:0];
				end
			end
			llp_pkg::OP_REMOVE: begin
				if (!find_slot(key, pos, prev)) begin
					ans.status = llp_pkg::ST_MISS;
				end else begin
					if (prev == NULL_SLOT)
						head_ptr = link_of[pos];
					else
						link_of[prev] = link_of[pos];
					link_of[pos] = free_ptr;
					free_ptr = pos;
					if (live > 0)
						live--;
					ans.slot = pos[5:0];
					ans.found = rec_of[pos];
				end
			end
			llp_pkg::OP_LOOKUP: begin
				if (!find_slot(key, pos, prev)) begin
					ans.status = llp_pkg::ST_MISS;
				end else begin
					ans.slot = pos[5:0];
					ans.found = rec_of[pos];
				end
			end
			default: ;
		endcase
		ans.entries = live[6:0];
	endfunction

	// Present one word, optionally after a random gap, and log its answer once taken
	task automatic send_word(input llp_pkg::op_t op, input logic [31:0] key,
			input logic [63:0] rec);
		pool_answer_t ans;
		if (!steady && $urandom_range(99) < 38) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < 38)
				@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'd0, rec, key, op};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pool_step(op, key, rec, ans);
		answers_due.push_back(ans);
	endtask

	// Drop valid and hold off until every answer is back
	task automatic wait_all_answers();
		s_axis_tvalid <= 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
	endtask

	// Output side: random backpressure, always ready while steady is set
	always @(posedge clk)
		m_axis_tready <= steady || ($urandom_range(99) >= 38);

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	// Compare each answer word with the oldest expectation
	always @(posedge clk) begin
		pool_answer_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (answers_due.size() == 0) begin
				$display("%0t: unexpected word, expected none actual %h", $time,
					m_axis_tdata);
				errors++;
			end else begin
				want = answers_due.pop_front();
				check_field("status", 64'(want.status), 64'(m_axis_tdata[1:0]));
				check_field("slot", 64'(want.slot), 64'(m_axis_tdata[7:2]));
				check_field("found_record", want.found, m_axis_tdata[71:8]);
				check_field("entries", 64'(want.entries), 64'(m_axis_tdata[78:72]));
			end
		end
	end

	// Watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Count, lookup and remove on an empty list
	task automatic test_empty_pool();
		send_word(llp_pkg::OP_COUNT, 32'h0, 64'h0);
		send_word(llp_pkg::OP_LOOKUP, 32'h8000_0000, 64'h0);
		send_word(llp_pkg::OP_REMOVE, 32'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
	endtask

	// Extreme keys and payloads
	task automatic test_key_extremes();
		send_word(llp_pkg::OP_INSERT, 32'h8000_0000, 64'h0);
		send_word(llp_pkg::OP_INSERT, 32'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		send_word(llp_pkg::OP_INSERT, 32'h0000_0000, 64'h5555_5555_5555_5555);
		send_word(llp_pkg::OP_INSERT, 32'hFFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA);
		send_word(llp_pkg::OP_LOOKUP, 32'h8000_0000, 64'h0);
		send_word(llp_pkg::OP_LOOKUP, 32'h7FFF_FFFF, 64'h0);
		send_word(llp_pkg::OP_LOOKUP, 32'h0000_0000, 64'h0);
		send_word(llp_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 64'h0);
		send_word(llp_pkg::OP_COUNT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
	endtask

	// Duplicate keys: newest record is found and removed first
	task automatic test_duplicate_keys();
		send_word(llp_pkg::OP_INSERT, 32'h0000_1234, 64'h0123_4567_89AB_CDEF);
		send_word(llp_pkg::OP_INSERT, 32'h0000_1234, 64'hFEDC_BA98_7654_3210);
		send_word(llp_pkg::OP_LOOKUP, 32'h0000_1234, 64'h0);
		send_word(llp_pkg::OP_REMOVE, 32'h0000_1234, 64'h0);
		send_word(llp_pkg::OP_LOOKUP, 32'h0000_1234, 64'h0);
	endtask

	// Sender holds off until the output side has caught up
	task automatic test_wait_for_drain();
		wait_all_answers();
		send_word(llp_pkg::OP_LOOKUP, 32'h7FFF_FFFF, 64'h0);
		send_word(llp_pkg::OP_COUNT, 32'h0, 64'h0);
	endtask

	// Unlink from the middle, the tail and the head, then reuse a freed slot
	task automatic test_unlink_positions();
		send_word(llp_pkg::OP_REMOVE, 32'h0000_0000, 64'h0);
		send_word(llp_pkg::OP_REMOVE, 32'h8000_0000, 64'h0);
		send_word(llp_pkg::OP_REMOVE, 32'h0000_1234, 64'h0);
		send_word(llp_pkg::OP_INSERT, 32'h1357_9BDF, 64'h1111_2222_3333_4444);
		send_word(llp_pkg::OP_COUNT, 32'h0, 64'h0);
	endtask

	// Fill the pool, get refused, walk a full list, then drain in random order
	task automatic test_pool_full();
		int i;
		int r;
		int cur;
		i = 0;
		while (live < POOL_DEPTH) begin
			send_word(llp_pkg::OP_INSERT, 32'hC000_0000 + i, {$urandom, $urandom});
			i++;
		end
		send_word(llp_pkg::OP_INSERT, 32'h2468_ACE0, 64'hDEAD_BEEF_0000_0001);
		send_word(llp_pkg::OP_COUNT, 32'h0, 64'h0);
		send_word(llp_pkg::OP_LOOKUP, 32'h2468_ACE0, 64'h0);
		send_word(llp_pkg::OP_REMOVE, 32'h2468_ACE0, 64'h0);
		send_word(llp_pkg::OP_REMOVE, key_of[head_ptr], 64'h0);
		send_word(llp_pkg::OP_INSERT, 32'h2468_ACE0, 64'hDEAD_BEEF_0000_0002);
		while (live > 0) begin
			r = $urandom_range(live - 1);
			cur = head_ptr;
			for (int n = 0; n < r; n++)
				cur = link_of[cur];
			send_word(llp_pkg::OP_REMOVE, key_of[cur], 64'h0);
		end
		send_word(llp_pkg::OP_COUNT, 32'h0, 64'h0);
	endtask

	// Random mix over a small set of hot keys plus fully random keys
	task automatic test_random_mix();
		logic [31:0] hot_keys[8];
		logic [31:0] key;
		int r;
		hot_keys[0] = 32'h8000_0000;
		hot_keys[1] = 32'h7FFF_FFFF;
		hot_keys[2] = 32'h0000_0000;
		hot_keys[3] = 32'hFFFF_FFFF;
		for (int k = 4; k < 8; k++)
			hot_keys[k] = $urandom;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			steady = (n >= 100 && n < 210);
			key = ($urandom_range(99) < 75) ? hot_keys[$urandom_range(7)] : $urandom;
			r = $urandom_range(99);
			if (r < 40)
				send_word(llp_pkg::OP_INSERT, key, {$urandom, $urandom});
			else if (r < 65)
				send_word(llp_pkg::OP_REMOVE, key, {$urandom, $urandom});
			else if (r < 90)
				send_word(llp_pkg::OP_LOOKUP, key, {$urandom, $urandom});
			else
				send_word(llp_pkg::OP_COUNT, key, {$urandom, $urandom});
		end
		steady = 1'b0;
	endtask

	initial begin
		pool_clear();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_pool();
		test_key_extremes();
		test_duplicate_keys();
		test_wait_for_drain();
		test_unlink_positions();
		test_pool_full();
		test_random_mix();
		wait_all_answers();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> linked_list_pool_with_free_list.f
sv/llp_pkg.sv
sv/llp_ram.sv
sv/llp_dpath.sv
sv/llp_ctrl.sv
sv/linked_list_pool_with_free_list.sv
sim/tb_linked_list_pool_with_free_list.sv
